>>> src/stt_pkg.sv
package stt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int MAX_FIRES   = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int FIRE_W      = $clog2(MAX_FIRES + 1);

  localparam int LABEL_W  = 16;
  localparam int COUNT_W  = 32;
  localparam int PERIOD_W = 10;
  localparam int OP_W     = 2;
  localparam int CODE_W   = 3;

  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TICK_PERIOD = '0;
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET    = PERIOD_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_REGISTER = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_KICK     = 2'd3
  } op_t;

  typedef enum logic [CODE_W-1:0] {
    RC_FIRED        = 3'd0,
    RC_DONE         = 3'd1,
    RC_FULL         = 3'd2,
    RC_NOT_FOUND    = 3'd3,
    RC_KICK_REFUSED = 3'd4
  } result_code_t;

  typedef struct packed {
    logic [COUNT_W-1:0] value;
    logic               zero;
  } sub_res_t;

endpackage

>>> src/stt_sat_sub.sv
module stt_sat_sub (
  input  logic [stt_pkg::COUNT_W-1:0]  minuend,
  input  logic [stt_pkg::PERIOD_W-1:0] subtrahend,
  output stt_pkg::sub_res_t            res
);
  import stt_pkg::*;

  logic [COUNT_W:0]   diff;
  logic [COUNT_W-1:0] value;

  // saturating countdown step
  assign diff  = {1'b0, minuend} - (COUNT_W + 1)'(subtrahend);
  assign value = diff[COUNT_W] ? '0 : diff[COUNT_W-1:0];

  assign res.value = value;
  assign res.zero  = (value == '0);

endmodule

>>> src/software_timer_table_core.sv
// Pool of sixteen labelled countdown timers driven by tick, register, remove and kick items.
// One shared saturating subtractor walks the slots one per cycle under a small sequencer,
// pausing while a fire waits on a busy output, so the block takes one item at a time: a tick
// is accepted, steps through every slot and ends with a done result, and a register, remove
// or kick is accepted, looks up every slot, updates the table and then sends its reply.
// Each fired label and the closing done result pass through a single output register, so
// a slow consumer that holds out_ready low stalls a tick. The tick period register sits at
// byte address 0 of the APB port and should be written only when idle.
module software_timer_table_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stt_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stt_pkg::OP_W-1:0]     op,
  input  logic [stt_pkg::LABEL_W-1:0]  timer_label,
  input  logic [stt_pkg::COUNT_W-1:0]  timeout_ms,
  input  logic                         allow_kick,
  input  logic                         repeat_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stt_pkg::CODE_W-1:0]   result_code,
  output logic [stt_pkg::LABEL_W-1:0]  fired_label,
  output logic                         last
);
  import stt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_LOOKUP,
    ST_APPLY,
    ST_REPLY
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMER_SLOTS - 1);

  state_t state;

  logic [PERIOD_W-1:0] tick_period;

  logic [TIMER_SLOTS-1:0] slot_used;
  logic [LABEL_W-1:0]     slot_key       [TIMER_SLOTS];
  logic [COUNT_W-1:0]     slot_timeout   [TIMER_SLOTS];
  logic [COUNT_W-1:0]     slot_remaining [TIMER_SLOTS];
  logic                   slot_reload    [TIMER_SLOTS];
  logic                   slot_kickable  [TIMER_SLOTS];

  logic [SLOT_W-1:0] idx;
  logic [FIRE_W-1:0] fires;

  op_t                cur_op;
  logic [LABEL_W-1:0] cur_label;
  logic [COUNT_W-1:0] cur_timeout;
  logic               cur_kick;
  logic               cur_repeat;

  logic               match_hit;
  logic [SLOT_W-1:0]  match_idx;
  logic               match_kickable;
  logic [COUNT_W-1:0] match_timeout;
  logic               free_hit;
  logic [SLOT_W-1:0]  free_idx;

  result_code_t       reply_code;
  logic [LABEL_W-1:0] reply_label;

  sub_res_t          sub_res;
  logic              out_free;
  logic              out_load;
  logic              fire_now;
  logic              cfg_wr;
  logic [SLOT_W-1:0] wr_idx;

  stt_sat_sub u_sub (
    .minuend    (slot_remaining[idx]),
    .subtrahend (tick_period),
    .res        (sub_res)
  );

  assign pready   = 1'b1;
  assign prdata   = (paddr[ADDR_W-1:2] == REG_TICK_PERIOD) ? 32'(tick_period) : '0;
  assign cfg_wr   = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_TICK_PERIOD);
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign fire_now = sub_res.zero && (fires < FIRE_W'(MAX_FIRES));
  assign wr_idx   = match_hit ? match_idx : free_idx;
  assign out_load = out_free &&
                    (((state == ST_TICK) && slot_used[idx] && fire_now) ||
                     (state == ST_REPLY));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tick_period <= PERIOD_RESET;
      slot_used   <= '0;
      out_valid   <= 1'b0;
      idx         <= '0;
      fires       <= '0;
      match_hit   <= 1'b0;
      free_hit    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        tick_period <= pwdata[PERIOD_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_op      <= op_t'(op);
            cur_label   <= timer_label;
            cur_timeout <= timeout_ms;
            cur_kick    <= allow_kick;
            cur_repeat  <= repeat_req;
            idx         <= '0;
            fires       <= '0;
            match_hit   <= 1'b0;
            free_hit    <= 1'b0;
            state       <= (op_t'(op) == OP_TICK) ? ST_TICK : ST_LOOKUP;
          end
        end

        ST_TICK: begin
          if (!slot_used[idx] || !fire_now || out_free) begin
            if (slot_used[idx]) begin
              if (fire_now) begin
                result_code <= RC_FIRED;
                fired_label <= slot_key[idx];
                last        <= 1'b0;
                fires       <= fires + FIRE_W'(1);
                if (slot_reload[idx]) begin
                  slot_remaining[idx] <= slot_timeout[idx];
                end else begin
                  slot_used[idx] <= 1'b0;
                end
              end else begin
                slot_remaining[idx] <= sub_res.value;
              end
            end
            if (idx == LAST_IDX) begin
              reply_code  <= RC_DONE;
              reply_label <= '0;
              state       <= ST_REPLY;
            end else begin
              idx <= idx + SLOT_W'(1);
            end
          end
        end

        ST_LOOKUP: begin
          if (slot_used[idx] && slot_key[idx] == cur_label && !match_hit) begin
            match_hit      <= 1'b1;
            match_idx      <= idx;
            match_kickable <= slot_kickable[idx];
            match_timeout  <= slot_timeout[idx];
          end
          if (!slot_used[idx] && !free_hit) begin
            free_hit <= 1'b1;
            free_idx <= idx;
          end
          if (idx == LAST_IDX) begin
            state <= ST_APPLY;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end

        ST_APPLY: begin
          reply_label <= cur_label;
          state       <= ST_REPLY;
          case (cur_op)
            OP_REGISTER: begin
              if (match_hit || free_hit) begin
                slot_used[wr_idx]      <= 1'b1;
                slot_key[wr_idx]       <= cur_label;
                slot_timeout[wr_idx]   <= cur_timeout;
                slot_remaining[wr_idx] <= cur_timeout;
                slot_reload[wr_idx]    <= cur_repeat;
                slot_kickable[wr_idx]  <= cur_kick;
                reply_code             <= RC_DONE;
              end else begin
                reply_code <= RC_FULL;
              end
            end
            OP_REMOVE: begin
              if (match_hit) begin
                slot_used[match_idx] <= 1'b0;
                reply_code           <= RC_DONE;
              end else begin
                reply_code <= RC_NOT_FOUND;
              end
            end
            OP_KICK: begin
              if (!match_hit) begin
                reply_code <= RC_NOT_FOUND;
              end else if (!match_kickable) begin
                reply_code <= RC_KICK_REFUSED;
              end else begin
                slot_remaining[match_idx] <= match_timeout;
                reply_code                <= RC_DONE;
              end
            end
            default: begin
              reply_code <= RC_DONE;
            end
          endcase
        end

        ST_REPLY: begin
          if (out_free) begin
            result_code <= reply_code;
            fired_label <= reply_label;
            last        <= 1'b1;
            state       <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/stt_checker.sv
module stt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [stt_pkg::CODE_W-1:0]  result_code,
  input logic [stt_pkg::LABEL_W-1:0] fired_label,
  input logic                        last
);
  import stt_pkg::*;

  // the block takes one item at a time, so no transfer directly after another
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous item in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result_code) && $stable(fired_label) && $stable(last)))
    else $error("stalled result changed");

  // only fire results are non-final
  a_last_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (result_code != RC_FIRED)))
    else $error("last flag inconsistent with result code");

  // a fire always belongs to a tick whose done is still to come
  a_fire_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_code == RC_FIRED) |-> !in_ready)
    else $error("ready while tick still open");

endmodule

bind software_timer_table_core stt_checker u_stt_checker (.*);

>>> tb/tb_software_timer_table_core.sv
module tb_software_timer_table_core;
  import stt_pkg::*;

  localparam logic [ADDR_W-1:0] PERIOD_ADDR   = {REG_TICK_PERIOD, 2'b00};
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 30;

  typedef struct {
    op_t                op;
    logic [LABEL_W-1:0] label;
    logic [COUNT_W-1:0] timeout;
    logic               kick_ok;
    logic               reload;
  } timer_cmd_t;

  typedef struct {
    result_code_t       code;
    logic [LABEL_W-1:0] label;
    logic               last;
  } timer_reply_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] op = '0;
  logic [LABEL_W-1:0] timer_label = '0;
  logic [COUNT_W-1:0] timeout_ms = '0;
  logic allow_kick = 1'b0;
  logic repeat_req = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CODE_W-1:0] result_code;
  logic [LABEL_W-1:0] fired_label;
  logic last;

  software_timer_table_core uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .timer_label(timer_label), .timeout_ms(timeout_ms),
    .allow_kick(allow_kick), .repeat_req(repeat_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_code(result_code), .fired_label(fired_label), .last(last)
  );

  // shadow of the timer pool
  logic [PERIOD_W-1:0] tick_ms = PERIOD_RESET;
  bit                  pool_used [TIMER_SLOTS];
  logic [LABEL_W-1:0]  pool_key [TIMER_SLOTS];
  logic [COUNT_W-1:0]  pool_timeout [TIMER_SLOTS];
  logic [COUNT_W-1:0]  pool_remaining [TIMER_SLOTS];
  bit                  pool_reload [TIMER_SLOTS];
  bit                  pool_kickable [TIMER_SLOTS];

  timer_cmd_t   timer_cmds [$];
  timer_reply_t due_replies [$];
  timer_cmd_t   cur_cmd;

  int fails = 0;
  int quiet_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_phase = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void push_reply(result_code_t code, logic [LABEL_W-1:0] label,
                                     logic fin);
    timer_reply_t r;
    r.code = code;
    r.label = label;
    r.last = fin;
    due_replies = {due_replies, r};
  endfunction

  function automatic void timer_pool_apply(timer_cmd_t c);
    int slot;
    int fires;
    slot = -1;
    fires = 0;
    if (c.op == OP_TICK) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        if (pool_used[i]) begin
          if (pool_remaining[i] > COUNT_W'(tick_ms))
            pool_remaining[i] = pool_remaining[i] - COUNT_W'(tick_ms);
          else
            pool_remaining[i] = '0;
          if (pool_remaining[i] == '0 && fires < MAX_FIRES) begin
            push_reply(RC_FIRED, pool_key[i], 1'b0);
            fires++;
            if (pool_reload[i])
              pool_remaining[i] = pool_timeout[i];
            else
              pool_used[i] = 1'b0;
          end
        end
      end
      push_reply(RC_DONE, '0, 1'b1);
      return;
    end
    for (int i = TIMER_SLOTS - 1; i >= 0; i--)
      if (pool_used[i] && pool_key[i] == c.label) slot = i;
    case (c.op)
      OP_REGISTER: begin
        if (slot < 0) begin
          for (int i = TIMER_SLOTS - 1; i >= 0; i--)
            if (!pool_used[i]) slot = i;
          if (slot < 0) begin
            push_reply(RC_FULL, c.label, 1'b1);
            return;
          end
          pool_used[slot] = 1'b1;
          pool_key[slot] = c.label;
        end
        pool_timeout[slot] = c.timeout;
        pool_remaining[slot] = c.timeout;
        pool_reload[slot] = c.reload;
        pool_kickable[slot] = c.kick_ok;
        push_reply(RC_DONE, c.label, 1'b1);
      end
      OP_REMOVE: begin
        if (slot < 0) begin
          push_reply(RC_NOT_FOUND, c.label, 1'b1);
        end else begin
          pool_used[slot] = 1'b0;
          push_reply(RC_DONE, c.label, 1'b1);
        end
      end
      default: begin
        if (slot < 0) begin
          push_reply(RC_NOT_FOUND, c.label, 1'b1);
        end else if (!pool_kickable[slot]) begin
          push_reply(RC_KICK_REFUSED, c.label, 1'b1);
        end else begin
          pool_remaining[slot] = pool_timeout[slot];
          push_reply(RC_DONE, c.label, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic void queue_cmd(op_t o, logic [LABEL_W-1:0] label,
                                    logic [COUNT_W-1:0] tmo, logic k, logic r);
    timer_cmd_t c;
    c.op = o;
    c.label = label;
    c.timeout = tmo;
    c.kick_ok = k;
    c.reload = r;
    timer_cmds = {timer_cmds, c};
  endfunction

  function automatic void queue_random_cmds(int count);
    int sel;
    int tsel;
    op_t o;
    logic [LABEL_W-1:0] label;
    logic [COUNT_W-1:0] tmo;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) o = OP_TICK;
      else if (sel < 70) o = OP_REGISTER;
      else if (sel < 85) o = OP_REMOVE;
      else o = OP_KICK;
      // mostly a small pool of labels so lookups hit
      if ($urandom_range(0, 7) == 0) label = LABEL_W'($urandom);
      else label = 16'h8000 + LABEL_W'($urandom_range(0, 23));
      tsel = $urandom_range(0, 9);
      if (tsel == 0) tmo = $urandom;
      else if (tsel == 1) tmo = '0;
      else tmo = COUNT_W'($urandom_range(0, 6 * int'(tick_ms) + 1));
      queue_cmd(o, label, tmo, 1'($urandom), 1'($urandom));
    end
  endfunction

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == PERIOD_ADDR) tick_ms = data[PERIOD_W-1:0];
  endtask

  task automatic wait_idle();
    while (timer_cmds.size() != 0 || due_replies.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) timer_pool_apply(cur_cmd);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (timer_cmds.size() != 0) begin
          cur_cmd = timer_cmds[0];
          timer_cmds.delete(0);
          in_valid <= 1'b1;
          op <= cur_cmd.op;
          timer_label <= cur_cmd.label;
          timeout_ms <= cur_cmd.timeout;
          allow_kick <= cur_cmd.kick_ok;
          repeat_req <= cur_cmd.reload;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 1;
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(30, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= (rx_phase % 3 == 0);
        default: out_ready <= 1'($urandom);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    timer_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_replies.size() == 0) begin
        $error("unexpected transfer: result_code %0d fired_label %h last %b",
               result_code, fired_label, last);
        fails++;
      end else begin
        want = due_replies[0];
        due_replies.delete(0);
        if (result_code !== want.code) begin
          $error("result_code: expected %0d, got %0d", want.code, result_code);
          fails++;
        end
        if (fired_label !== want.label) begin
          $error("fired_label: expected %h, got %h", want.label, fired_label);
          fails++;
        end
        if (last !== want.last) begin
          $error("last: expected %b, got %b", want.last, last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_cmd(OP_TICK, 16'h0000, '0, 1'b0, 1'b0);
    queue_cmd(OP_REGISTER, 16'h0000, '0, 1'b1, 1'b1);
    queue_cmd(OP_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_cmd(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    queue_cmd(OP_KICK, 16'hFFFF, '0, 1'b0, 1'b0);
    queue_cmd(OP_KICK, 16'h1234, '0, 1'b0, 1'b0);
    queue_cmd(OP_REMOVE, 16'h1234, '0, 1'b0, 1'b0);
    queue_cmd(OP_REGISTER, 16'h0005, 32'd2, 1'b1, 1'b0);
    queue_cmd(OP_TICK, 16'h0000, '0, 1'b0, 1'b0);
    queue_cmd(OP_KICK, 16'h0005, '0, 1'b0, 1'b0);
    queue_cmd(OP_REGISTER, 16'h0005, 32'd1, 1'b0, 1'b1);
    queue_cmd(OP_TICK, 16'h0000, '0, 1'b0, 1'b0);
    queue_cmd(OP_REMOVE, 16'h0000, '0, 1'b0, 1'b0);
    // fill the pool, then one more
    for (int i = 0; i < TIMER_SLOTS - 2; i++)
      queue_cmd(OP_REGISTER, 16'h8000 + LABEL_W'(i), 32'd1, 1'(i), 1'(i >> 1));
    queue_cmd(OP_REGISTER, 16'h7FFF, 32'd1, 1'b1, 1'b1);
    queue_cmd(OP_TICK, 16'h0000, '0, 1'b0, 1'b0);
    queue_cmd(OP_REMOVE, 16'hFFFF, '0, 1'b0, 1'b0);
    wait_idle();

    // frozen countdowns
    apb_write(PERIOD_ADDR, 32'd0);
    apb_write(UNMAPPED_ADDR, 32'd5);
    queue_random_cmds(60);
    wait_idle();

    apb_write(PERIOD_ADDR, 32'd1000);
    queue_random_cmds(110);
    wait_idle();

    apb_write(PERIOD_ADDR, 32'hFFFF_F403);
    queue_random_cmds(110);
    wait_idle();

    apb_write(PERIOD_ADDR, 32'd1);
    queue_random_cmds(120);
    wait_idle();

    repeat (40) @(posedge clk);
    if (fails == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/stt_pkg.sv
src/stt_sat_sub.sv
src/software_timer_table_core.sv
src/stt_checker.sv
tb/tb_software_timer_table_core.sv
